### hdl/pmd_pkg.sv
// Shared constants, register codes and inter-module types of the prototype mask decoder.
package pmd_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int SAMPLE_BITS  = 16;

  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int CNT_W   = CH_W + 1;
  localparam int X_W     = $clog2(MAX_WIDTH);
  localparam int Y_W     = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = X_W + 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W   = 40;
  localparam int Q16_W   = 17;
  localparam int AREA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int NEED_W  = Q16_W + AREA_W;
  localparam int COUNT_W = 17;

  localparam logic [Q16_W-1:0]   ONE_Q16   = Q16_W'(65536);
  localparam logic [Q16_W-1:0]   ROUND_Q16 = Q16_W'(65535);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_WIDTH      = 3'd0,
    REG_MASK_HEIGHT     = 3'd1,
    REG_CHANNELS_IN_USE = 3'd2,
    REG_LOGIT_THRESHOLD = 3'd3,
    REG_BOX_LEFT        = 3'd4,
    REG_BOX_TOP         = 3'd5,
    REG_BOX_WIDTH       = 3'd6,
    REG_BOX_HEIGHT      = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PROTO = 1'b1
  } op_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [CNT_W-1:0]  channels;
    logic [SIZE_W-1:0] x0;
    logic [SIZE_W-1:0] x1;
    logic [SIZE_W-1:0] y0;
    logic [SIZE_W-1:0] y1;
    logic [AREA_W-1:0] area;
  } geom_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [X_W-1:0]          px;
    logic [Y_W-1:0]          py;
    logic                    last;
    logic [NEED_W-1:0]       need;
  } pixel_t;

endpackage

### hdl/pmd_geometry.sv
// Size limits, clamped box bounds in pixels and plane area, registered from configuration.
module pmd_geometry (
  input  logic                        clk,
  input  logic [pmd_pkg::SIZE_W-1:0]  mask_width,
  input  logic [pmd_pkg::SIZE_W-1:0]  mask_height,
  input  logic [pmd_pkg::CNT_W-1:0]   channels_in_use,
  input  logic [pmd_pkg::Q16_W-1:0]   box_left,
  input  logic [pmd_pkg::Q16_W-1:0]   box_top,
  input  logic [pmd_pkg::Q16_W-1:0]   box_width,
  input  logic [pmd_pkg::Q16_W-1:0]   box_height,
  output pmd_pkg::geom_t              geom
);
  import pmd_pkg::*;

  localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(MAX_HEIGHT);
  localparam logic [CNT_W-1:0]  C_MAX = CNT_W'(MAX_CHANNELS);
  localparam int                BP_W  = Q16_W + SIZE_W;

  logic [SIZE_W-1:0]   w_lim;
  logic [SIZE_W-1:0]   h_lim;
  logic [CNT_W-1:0]    c_lim;
  logic [Q16_W-1:0]    bx;
  logic [Q16_W-1:0]    by;
  logic [Q16_W-1:0]    bw;
  logic [Q16_W-1:0]    bh;
  logic [Q16_W:0]      right_sum;
  logic [Q16_W:0]      bottom_sum;
  logic [Q16_W-1:0]    right;
  logic [Q16_W-1:0]    bottom;
  logic [BP_W-1:0]     x0_prod;
  logic [BP_W-1:0]     y0_prod;
  logic [BP_W-1:0]     x1_prod;
  logic [BP_W-1:0]     y1_prod;
  logic [2*SIZE_W-1:0] area_prod;
  geom_t               geom_next;

  always_comb begin
    w_lim = (mask_width == '0) ? SIZE_W'(1) : ((mask_width > W_MAX) ? W_MAX : mask_width);
    h_lim = (mask_height == '0) ? SIZE_W'(1) : ((mask_height > H_MAX) ? H_MAX : mask_height);
    c_lim = (channels_in_use == '0) ? CNT_W'(1) :
            ((channels_in_use > C_MAX) ? C_MAX : channels_in_use);

    bx = (box_left   > ONE_Q16) ? ONE_Q16 : box_left;
    by = (box_top    > ONE_Q16) ? ONE_Q16 : box_top;
    bw = (box_width  > ONE_Q16) ? ONE_Q16 : box_width;
    bh = (box_height > ONE_Q16) ? ONE_Q16 : box_height;

    right_sum  = {1'b0, bx} + {1'b0, bw};
    bottom_sum = {1'b0, by} + {1'b0, bh};
    right  = (right_sum  > {1'b0, ONE_Q16}) ? ONE_Q16 : right_sum[Q16_W-1:0];
    bottom = (bottom_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : bottom_sum[Q16_W-1:0];

    x0_prod   = bx * w_lim;
    y0_prod   = by * h_lim;
    x1_prod   = right * w_lim + BP_W'(ROUND_Q16);
    y1_prod   = bottom * h_lim + BP_W'(ROUND_Q16);
    area_prod = w_lim * h_lim;

    geom_next.width    = w_lim;
    geom_next.height   = h_lim;
    geom_next.channels = c_lim;
    geom_next.x0       = x0_prod[16 +: SIZE_W];
    geom_next.y0       = y0_prod[16 +: SIZE_W];
    geom_next.x1       = x1_prod[16 +: SIZE_W];
    geom_next.y1       = y1_prod[16 +: SIZE_W];
    geom_next.area     = area_prod[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

### hdl/pmd_mac.sv
// Input register, coefficient store, channel and position counters, multiply and accumulate.
module pmd_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [pmd_pkg::CH_W-1:0]           coeff_slot,
  input  logic signed [pmd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [pmd_pkg::Q16_W-1:0]          area_floor,
  input  pmd_pkg::geom_t                     geom,
  output logic                               pix_valid,
  output pmd_pkg::pixel_t                    pix,
  input  logic                               pix_ready
);
  import pmd_pkg::*;

  logic                          a_valid;
  op_t                           a_op;
  logic [CH_W-1:0]               a_slot;
  logic signed [SAMPLE_BITS-1:0] a_sample;
  logic [Q16_W-1:0]              a_ratio;

  logic                          b_valid;
  logic                          b_first;
  logic                          b_done;
  logic signed [PROD_W-1:0]      b_prod;
  logic [X_W-1:0]                b_px;
  logic [Y_W-1:0]                b_py;
  logic                          b_last;
  logic [NEED_W-1:0]             b_need;

  logic signed [SAMPLE_BITS-1:0] store [MAX_CHANNELS];
  logic [CH_W-1:0]               ch_count;
  logic [X_W-1:0]                col_count;
  logic [Y_W-1:0]                row_count;
  logic signed [SUM_W-1:0]       dot_sum;
  logic [Q16_W-1:0]              pixel_ratio;

  logic                          in_fire;
  logic                          a_fire;
  logic                          a_ready;
  logic                          b_fire;
  logic                          b_ready;
  logic                          c_ready;
  logic                          a_first;
  logic                          a_done;
  logic                          last_x;
  logic                          last_y;
  logic signed [SAMPLE_BITS-1:0] coef;
  logic signed [PROD_W-1:0]      a_prod;
  logic [Q16_W-1:0]              a_ratio_sel;
  logic [NEED_W-1:0]             a_need_new;
  logic signed [SUM_W-1:0]       sum_base;
  logic signed [SUM_W-1:0]       sum_next;

  assign c_ready  = !pix_valid || pix_ready;
  assign b_fire   = b_valid && (!b_done || c_ready);
  assign b_ready  = !b_valid || b_fire;
  assign a_fire   = a_valid && (a_op == OP_LOAD || b_ready);
  assign a_ready  = !a_valid || a_fire;
  assign in_stall = !a_ready;
  assign in_fire  = in_valid && a_ready;

  assign a_first     = (ch_count == '0);
  assign a_done      = ({1'b0, ch_count} + CNT_W'(1)) >= geom.channels;
  assign last_x      = ({1'b0, col_count} + SIZE_W'(1)) >= geom.width;
  assign last_y      = ({1'b0, row_count} + SIZE_W'(1)) >= geom.height;
  assign coef        = store[ch_count];
  assign a_prod      = coef * a_sample;
  assign a_ratio_sel = a_first ? a_ratio : pixel_ratio;
  assign a_need_new  = a_ratio_sel * geom.area;

  assign sum_base = b_first ? '0 : dot_sum;
  assign sum_next = sum_base + {{(SUM_W-PROD_W){b_prod[PROD_W-1]}}, b_prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op     <= op_t'(operation);
      a_slot   <= coeff_slot;
      a_sample <= sample;
      a_ratio  <= area_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_op == OP_LOAD) begin
      store[a_slot] <= a_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_count  <= '0;
      col_count <= '0;
      row_count <= '0;
    end else if (a_fire && a_op == OP_PROTO) begin
      if (a_done) begin
        ch_count <= '0;
        if (last_x && last_y) begin
          col_count <= '0;
          row_count <= '0;
        end else if (last_x) begin
          col_count <= '0;
          row_count <= row_count + Y_W'(1);
        end else begin
          col_count <= col_count + X_W'(1);
        end
      end else begin
        ch_count <= ch_count + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_op == OP_PROTO) begin
      b_first <= a_first;
      b_done  <= a_done;
      b_prod  <= a_prod;
      b_px    <= col_count;
      b_py    <= row_count;
      b_last  <= last_x && last_y;
      b_need  <= a_need_new;
      if (a_first) begin
        pixel_ratio <= a_ratio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_fire && a_op == OP_PROTO) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum <= '0;
    end else if (b_fire) begin
      dot_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_done) begin
      pix.sum  <= sum_next;
      pix.px   <= b_px;
      pix.py   <= b_py;
      pix.last <= b_last;
      pix.need <= b_need;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (b_fire && b_done) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  a_load_lands: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_op == OP_LOAD |=> store[$past(a_slot)] == $past(a_sample))
    else $error("coefficient load did not reach the store");

  a_channel_wrap: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_op == OP_PROTO && a_done |=> ch_count == '0)
    else $error("channel counter did not wrap at pixel end");

endmodule

### hdl/pmd_result.sv
// Threshold, box crop, active count, area check and the result register.
module pmd_result (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  input  pmd_pkg::pixel_t                    pix,
  output logic                               pix_ready,
  input  pmd_pkg::geom_t                     geom,
  input  logic signed [pmd_pkg::SUM_W-1:0]   logit_threshold,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pmd_pkg::X_W-1:0]            pixel_x,
  output logic [pmd_pkg::Y_W-1:0]            pixel_y,
  output logic                               mask_on,
  output logic [pmd_pkg::COUNT_W-1:0]        active_count,
  output logic                               area_ok,
  output logic                               last
);
  import pmd_pkg::*;

  logic [COUNT_W-1:0] active_total;
  logic               c_fire;
  logic               above;
  logic               in_box;
  logic               on;
  logic [COUNT_W-1:0] active_inc;
  logic [COUNT_W-1:0] count_next;
  logic               ok_on;
  logic               ok_off;
  logic               ok;

  assign pix_ready = !out_valid || !out_stall;
  assign c_fire    = pix_valid && pix_ready;

  assign above  = $signed(pix.sum) >= logit_threshold;
  assign in_box = ({1'b0, pix.px} >= geom.x0) && ({1'b0, pix.px} < geom.x1) &&
                  ({1'b0, pix.py} >= geom.y0) && ({1'b0, pix.py} < geom.y1);
  assign on     = above && in_box;

  assign active_inc = (active_total == COUNT_MAX) ? active_total : active_total + COUNT_W'(1);
  assign count_next = on ? active_inc : active_total;
  assign ok_on      = NEED_W'({active_inc, 16'h0000}) >= pix.need;
  assign ok_off     = NEED_W'({active_total, 16'h0000}) >= pix.need;
  assign ok         = pix.last && (on ? ok_on : ok_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_total <= '0;
    end else if (c_fire) begin
      active_total <= pix.last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      pixel_x      <= pix.px;
      pixel_y      <= pix.py;
      mask_on      <= on;
      active_count <= count_next;
      area_ok      <= ok;
      last         <= pix.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_plane_restart: assert property (@(posedge clk) disable iff (rst)
    c_fire && pix.last |=> active_total == '0)
    else $error("active count not cleared after the last pixel");

  a_area_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && area_ok |-> last)
    else $error("area flag raised on a pixel other than the last");

endmodule

### hdl/prototype_mask_decoder.sv
// Top level of the prototype mask decoder: configuration registers and stage wiring.
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+----------------------------------------------
//  input    | in_valid / in_stall   | operation, coeff_slot, sample, area_floor
//  result   | out_valid / out_stall | pixel_x, pixel_y, mask_on, active_count,
//           |                       | area_ok, last
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input beat per cycle while in_stall is low; the 16x16 coefficient multiply
// and the 40-bit accumulate each take a stage, ahead of the pixel and result registers.
// rst is synchronous: pipeline, counters and the accumulator clear, registers take their
// defaults; the coefficient store is not cleared and must be loaded before use.
// out_stall holds the result register; the stages behind it keep taking beats until
// they fill, up to three pixels deep, and only then raise in_stall.
module prototype_mask_decoder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   operation,
  input  logic [pmd_pkg::CH_W-1:0]               coeff_slot,
  input  logic signed [pmd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [pmd_pkg::Q16_W-1:0]              area_floor,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [pmd_pkg::X_W-1:0]                pixel_x,
  output logic [pmd_pkg::Y_W-1:0]                pixel_y,
  output logic                                   mask_on,
  output logic [pmd_pkg::COUNT_W-1:0]            active_count,
  output logic                                   area_ok,
  output logic                                   last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import pmd_pkg::*;

  logic [SIZE_W-1:0]       mask_width;
  logic [SIZE_W-1:0]       mask_height;
  logic [CNT_W-1:0]        channels_in_use;
  logic signed [SUM_W-1:0] logit_threshold;
  logic [Q16_W-1:0]        box_left;
  logic [Q16_W-1:0]        box_top;
  logic [Q16_W-1:0]        box_width;
  logic [Q16_W-1:0]        box_height;

  geom_t                   geom;
  logic                    pix_valid;
  pixel_t                  pix;
  logic                    pix_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width      <= SIZE_W'(160);
      mask_height     <= SIZE_W'(160);
      channels_in_use <= CNT_W'(MAX_CHANNELS);
      logit_threshold <= '0;
      box_left        <= '0;
      box_top         <= '0;
      box_width       <= ONE_Q16;
      box_height      <= ONE_Q16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MASK_WIDTH:      mask_width      <= cfg_data[SIZE_W-1:0];
        REG_MASK_HEIGHT:     mask_height     <= cfg_data[SIZE_W-1:0];
        REG_CHANNELS_IN_USE: channels_in_use <= cfg_data[CNT_W-1:0];
        REG_LOGIT_THRESHOLD: logit_threshold <= $signed(cfg_data[SUM_W-1:0]);
        REG_BOX_LEFT:        box_left        <= cfg_data[Q16_W-1:0];
        REG_BOX_TOP:         box_top         <= cfg_data[Q16_W-1:0];
        REG_BOX_WIDTH:       box_width       <= cfg_data[Q16_W-1:0];
        REG_BOX_HEIGHT:      box_height      <= cfg_data[Q16_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pmd_geometry u_geometry (
    .clk             (clk),
    .mask_width      (mask_width),
    .mask_height     (mask_height),
    .channels_in_use (channels_in_use),
    .box_left        (box_left),
    .box_top         (box_top),
    .box_width       (box_width),
    .box_height      (box_height),
    .geom            (geom)
  );

  pmd_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .coeff_slot     (coeff_slot),
    .sample         (sample),
    .area_floor     (area_floor),
    .geom           (geom),
    .pix_valid      (pix_valid),
    .pix            (pix),
    .pix_ready      (pix_ready)
  );

  pmd_result u_result (
    .clk             (clk),
    .rst             (rst),
    .pix_valid       (pix_valid),
    .pix             (pix),
    .pix_ready       (pix_ready),
    .geom            (geom),
    .logit_threshold (logit_threshold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .mask_on         (mask_on),
    .active_count    (active_count),
    .area_ok         (area_ok),
    .last            (last)
  );

endmodule

### dv/tb_prototype_mask_decoder.sv
// Testbench for prototype_mask_decoder: directed and random beats checked against a pixel predictor.
`timescale 1ns / 100ps

module tb_prototype_mask_decoder;
  import pmd_pkg::*;

  localparam int HOLDOFF_CYCLES = 200;

  typedef struct {
    op_t                     op;
    logic [CH_W-1:0]         slot;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [Q16_W-1:0]        ratio;
    bit                      drain;
  } beat_t;

  typedef struct {
    logic [X_W-1:0]     px;
    logic [Y_W-1:0]     py;
    logic               on;
    logic [COUNT_W-1:0] count;
    logic               ok;
    logic               lst;
  } pixel_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          operation = OP_LOAD;
  logic [CH_W-1:0]               coeff_slot = '0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic [Q16_W-1:0]              area_floor = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [X_W-1:0]                pixel_x;
  logic [Y_W-1:0]                pixel_y;
  logic                          mask_on;
  logic [COUNT_W-1:0]            active_count;
  logic                          area_ok;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  beat_t         stim_beats[$];
  pixel_result_t expected_pixels[$];
  beat_t         next_beat;
  pixel_result_t got_pixel;
  int            mismatches = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            holdoff_reqs = 0;
  int            holdoff_seen = 0;
  int            holdoff_left = 0;

  logic [8:0]         cur_width = 9'd160;
  logic [8:0]         cur_height = 9'd160;
  logic [5:0]         cur_chans = 6'd32;
  logic [SUM_W-1:0]   cur_thr = '0;
  logic [Q16_W-1:0]   cur_left = '0;
  logic [Q16_W-1:0]   cur_top = '0;
  logic [Q16_W-1:0]   cur_bw = 17'd65536;
  logic [Q16_W-1:0]   cur_bh = 17'd65536;

  logic signed [SAMPLE_BITS-1:0] coeffs [MAX_CHANNELS];
  logic [SUM_W-1:0]   acc = '0;
  int                 chan_idx = 0;
  int                 col = 0;
  int                 row = 0;
  int                 active = 0;
  int                 area_min = 0;

  prototype_mask_decoder u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int size_lim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic longint clamp_q16(logic [Q16_W-1:0] v);
    return (v > 65536) ? 65536 : longint'(v);
  endfunction

  function automatic void decode_beat(op_t op, logic [CH_W-1:0] slot,
                                      logic signed [SAMPLE_BITS-1:0] smp,
                                      logic [Q16_W-1:0] ratio);
    int w, h, c;
    longint bx, by, bw, bh, x0, x1, y0, y1;
    bit on, last_x, at_end, ok;
    pixel_result_t res;
    if (op == OP_LOAD) begin
      coeffs[slot] = smp;
      return;
    end
    w = size_lim(int'(cur_width), MAX_WIDTH);
    h = size_lim(int'(cur_height), MAX_HEIGHT);
    c = size_lim(int'(cur_chans), MAX_CHANNELS);
    if (chan_idx == 0) begin
      area_min = int'(ratio);
      acc = '0;
    end
    acc = acc + SUM_W'(longint'(coeffs[chan_idx]) * longint'(smp));
    chan_idx++;
    if (chan_idx < c) return;
    chan_idx = 0;

    bx = clamp_q16(cur_left);
    by = clamp_q16(cur_top);
    bw = clamp_q16(cur_bw);
    bh = clamp_q16(cur_bh);
    if (bx + bw > 65536) bw = 65536 - bx;
    if (by + bh > 65536) bh = 65536 - by;
    x0 = (bx * w) >> 16;
    y0 = (by * h) >> 16;
    x1 = ((bx + bw) * w + 65535) >> 16;
    y1 = ((by + bh) * h + 65535) >> 16;

    on = $signed(acc) >= $signed(cur_thr);
    if (col < x0 || col >= x1 || row < y0 || row >= y1) on = 1'b0;
    if (on && active < 131071) active++;
    last_x = (col + 1 >= w);
    at_end = last_x && (row + 1 >= h);
    ok = at_end && (longint'(active) * 65536 >= longint'(area_min) * w * h);

    res.px = X_W'(col);
    res.py = Y_W'(row);
    res.on = on;
    res.count = COUNT_W'(active);
    res.ok = ok;
    res.lst = at_end;
    expected_pixels.insert(expected_pixels.size(), res);

    if (at_end) begin
      col = 0;
      row = 0;
      active = 0;
    end else if (last_x) begin
      col = 0;
      row = row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic void check_field(string fname, logic [COUNT_W-1:0] want,
                                      logic [COUNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t %s: expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [Q16_W-1:0] rand_ratio();
    case ($urandom_range(7))
      0: return '0;
      1: return ONE_Q16;
      2: return Q16_W'($urandom_range(65537, 131071));
      default: return Q16_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [Q16_W-1:0] rand_q16();
    case ($urandom_range(5))
      0: return '0;
      1: return ONE_Q16;
      2: return Q16_W'($urandom_range(65537, 131071));
      default: return Q16_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] rand_thr();
    case ($urandom_range(7))
      0: return {1'b0, {(SUM_W-1){1'b1}}};
      1: return {1'b1, {(SUM_W-1){1'b0}}};
      2: return '0;
      3: return SUM_W'({$urandom, $urandom});
      default: return SUM_W'(longint'($signed($urandom)) >>> 3);
    endcase
  endfunction

  function automatic void add_beat(op_t op, int slot, logic signed [SAMPLE_BITS-1:0] smp,
                                   logic [Q16_W-1:0] ratio, bit drain);
    beat_t b;
    b.op = op;
    b.slot = CH_W'(slot);
    b.smp = smp;
    b.ratio = ratio;
    b.drain = drain;
    stim_beats.insert(stim_beats.size(), b);
  endfunction

  function automatic void add_pixels(int n_pix, int chans, int drain_at);
    for (int p = 0; p < n_pix; p++) begin
      for (int ch = 0; ch < chans; ch++) begin
        if ($urandom_range(19) == 0)
          add_beat(OP_LOAD, $urandom_range(31), rand_sample(), rand_ratio(), 1'b0);
        add_beat(OP_PROTO, $urandom_range(31), rand_sample(), rand_ratio(),
                 p == drain_at && ch == 0);
      end
    end
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MASK_WIDTH:      cur_width  = data[8:0];
      REG_MASK_HEIGHT:     cur_height = data[8:0];
      REG_CHANNELS_IN_USE: cur_chans  = data[5:0];
      REG_LOGIT_THRESHOLD: cur_thr    = data[SUM_W-1:0];
      REG_BOX_LEFT:        cur_left   = data[Q16_W-1:0];
      REG_BOX_TOP:         cur_top    = data[Q16_W-1:0];
      REG_BOX_WIDTH:       cur_bw     = data[Q16_W-1:0];
      REG_BOX_HEIGHT:      cur_bh     = data[Q16_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (stim_beats.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 71; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 71; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        decode_beat(op_t'(operation), coeff_slot, sample, area_floor);
      if (!in_valid || !in_stall) begin
        if (stim_beats.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(stim_beats[0].drain && expected_pixels.size() != 0)) begin
          next_beat = stim_beats.pop_front();
          in_valid       <= 1'b1;
          operation      <= next_beat.op;
          coeff_slot     <= next_beat.slot;
          sample         <= next_beat.smp;
          area_floor     <= next_beat.ratio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t pixel: expected none, actual x=%0d y=%0d", $time, pixel_x, pixel_y);
        end else begin
          got_pixel = expected_pixels.pop_front();
          check_field("pixel_x", got_pixel.px, pixel_x);
          check_field("pixel_y", got_pixel.py, pixel_y);
          check_field("mask_on", got_pixel.on, mask_on);
          check_field("active_count", got_pixel.count, active_count);
          check_field("area_ok", got_pixel.ok, area_ok);
          check_field("last", got_pixel.lst, last);
        end
      end
      if (holdoff_seen != holdoff_reqs) begin
        holdoff_seen = holdoff_reqs;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] dir_smp [12] = '{
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000,
      16'shFFFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000};
    logic [Q16_W-1:0] dir_ratio [6] = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd32768,
                                        17'd131071};
    int chan, c_eff, n_pix;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    cfg_write(REG_MASK_WIDTH, 3);
    cfg_write(REG_MASK_HEIGHT, 2);
    cfg_write(REG_CHANNELS_IN_USE, 2);
    cfg_write(REG_LOGIT_THRESHOLD, 0);
    cfg_write(REG_BOX_LEFT, 30000);
    cfg_write(REG_BOX_WIDTH, 20000);
    add_beat(OP_LOAD, 0, 16'sh7FFF, '0, 1'b0);
    add_beat(OP_LOAD, 1, 16'sh8000, '0, 1'b0);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) add_beat(OP_LOAD, 1, 16'sh8000, '0, 1'b0);
      add_beat(OP_PROTO, i, dir_smp[i], dir_ratio[i / 2], 1'b0);
    end
    settle();
    cfg_write(REG_MASK_WIDTH, 1);
    cfg_write(REG_MASK_HEIGHT, 1);
    cfg_write(REG_CHANNELS_IN_USE, 1);
    cfg_write(REG_LOGIT_THRESHOLD, {1'b0, {(SUM_W-1){1'b1}}});
    cfg_write(REG_BOX_LEFT, 0);
    cfg_write(REG_BOX_WIDTH, 65536);
    add_beat(OP_PROTO, 0, 16'sh7FFF, '0, 1'b0);
    settle();
    cfg_write(REG_LOGIT_THRESHOLD, {1'b1, {(SUM_W-1){1'b0}}});
    add_beat(OP_PROTO, 0, 16'sh8000, ONE_Q16, 1'b0);

    for (int i = 0; i < MAX_CHANNELS; i++)
      add_beat(OP_LOAD, i, rand_sample(), rand_ratio(), 1'b0);

    for (int k = 0; k < 4; k++) begin
      settle();
      set_idling(k % 4);
      cfg_write(REG_MASK_WIDTH, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6));
      cfg_write(REG_MASK_HEIGHT, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6));
      if (k == 1)
        chan = 63;
      else if (k == 2)
        chan = 0;
      else if ($urandom_range(3) == 0)
        chan = $urandom_range(5, 32);
      else
        chan = $urandom_range(1, 4);
      cfg_write(REG_CHANNELS_IN_USE, chan);
      cfg_write(REG_LOGIT_THRESHOLD, rand_thr());
      cfg_write(REG_BOX_LEFT, rand_q16());
      cfg_write(REG_BOX_TOP, rand_q16());
      cfg_write(REG_BOX_WIDTH, rand_q16());
      cfg_write(REG_BOX_HEIGHT, rand_q16());
      c_eff = size_lim(chan, MAX_CHANNELS);
      n_pix = 1 + 16 / c_eff;
      add_pixels(n_pix, c_eff, ($urandom_range(2) == 0) ? $urandom_range(n_pix - 1) : -1);
      if (c_eff > 1 && $urandom_range(2) == 0)
        add_pixels(1, $urandom_range(1, c_eff - 1), -1);
    end

    // full-width row, then hold the result side so the input backs up
    settle();
    set_idling(0);
    cfg_write(REG_MASK_WIDTH, 256);
    cfg_write(REG_MASK_HEIGHT, 0);
    cfg_write(REG_CHANNELS_IN_USE, 1);
    cfg_write(REG_LOGIT_THRESHOLD, rand_thr());
    cfg_write(REG_BOX_LEFT, $urandom_range(0, 65536));
    cfg_write(REG_BOX_TOP, 0);
    cfg_write(REG_BOX_WIDTH, $urandom_range(0, 65536));
    cfg_write(REG_BOX_HEIGHT, 65536);
    add_pixels(256, 1, 128);
    holdoff_reqs++;

    // full-height column
    settle();
    set_idling(3);
    cfg_write(REG_MASK_WIDTH, 0);
    cfg_write(REG_MASK_HEIGHT, 511);
    cfg_write(REG_LOGIT_THRESHOLD, rand_thr());
    cfg_write(REG_BOX_LEFT, 0);
    cfg_write(REG_BOX_TOP, $urandom_range(0, 65536));
    cfg_write(REG_BOX_WIDTH, 65536);
    cfg_write(REG_BOX_HEIGHT, $urandom_range(0, 131071));
    add_pixels(256, 1, -1);

    settle();
    if (mismatches == 0)
      $display("prototype_mask_decoder: match");
    else
      $display("prototype_mask_decoder: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("prototype_mask_decoder: mismatch");
    $finish;
  end

endmodule

### filelist.f
hdl/pmd_pkg.sv
hdl/pmd_geometry.sv
hdl/pmd_mac.sv
hdl/pmd_result.sv
hdl/prototype_mask_decoder.sv
dv/tb_prototype_mask_decoder.sv
